FILE: hw/rtl/rsbt_pkg.sv
`timescale 1ns / 1ps

package rsbt_pkg;

    // Field widths fixed by the record format.
    localparam int SCORE_W  = 10;
    localparam int TOTAL_W  = 12;
    localparam int NUMBER_W = 7;

    typedef struct packed {
        logic [SCORE_W-1:0] score_first;
        logic [SCORE_W-1:0] score_second;
        logic [SCORE_W-1:0] score_third;
        logic               last_record;
    } t_in_item;

    typedef struct packed {
        logic [NUMBER_W-1:0] record_number;
        logic [TOTAL_W-1:0]  total_score;
        logic                last_out;
    } t_out_item;

    // One stored record as it sits in the record memory.
    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [TOTAL_W-1:0]  total;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

FILE: hw/rtl/rsbt_ram.sv
`timescale 1ns / 1ps

module rsbt_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/record_sort_by_total_desc_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Valid         Stall         Payload
// request   in         i_in_valid    o_in_stall    i_in_data  (t_in_item)
// result    out        o_out_valid   i_out_stall   o_out_data (t_out_item)
//
// A request not marked last is stored, if the store has room, and gives no result.
// For a set of n records the sort makes nested passes over the record memory, which
// has a single read and write port. Each result is then read out, captured in S_OCAP
// and held in S_OHOLD for as long as i_out_stall is high.
// Reset is synchronous and only clears the sequencer and the record count; the
// record memory is never cleared, since only entries written in the current set are read.
// o_in_stall stays high from the last request of a set until its final result leaves.

module record_sort_by_total_desc_unit
    import rsbt_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // One-hot sequencer states. The sort runs as nested passes: FETCH and HEAD
    // load the record at position i into r_cur, SCAN walks j over the later
    // positions, and PUT writes the pass winner back to position i.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_PUT   = 8'b0001_0000,
        S_ORD   = 8'b0010_0000,
        S_OCAP  = 8'b0100_0000,
        S_OHOLD = 8'b1000_0000
    } t_state;

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    t_rec      r_cur, n_cur;
    t_out_item r_out, n_out;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_rec             w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [REC_W-1:0] w_rdata_raw;
    t_rec             w_rdata;

    logic                  w_full;
    logic [TOTAL_W-1:0]    w_sum;
    logic [CW+NUMBER_W-1:0] w_number_ext;

    assign w_rdata = t_rec'(w_rdata_raw);
    assign w_full  = (r_count == CW'(MAX_RECORDS));

    // The total is an exact sum; three 10-bit scores always fit in 12 bits.
    assign w_sum = TOTAL_W'(i_in_data.score_first) + TOTAL_W'(i_in_data.score_second)
                 + TOTAL_W'(i_in_data.score_third);

    // Serial numbers count from 1 and wrap at the width of the number field.
    assign w_number_ext = (CW + NUMBER_W)'(r_count) + (CW + NUMBER_W)'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cur   = r_cur;
        n_out   = r_out;
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = r_cur;
        w_re    = 1'b0;
        w_raddr = r_i;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // A record that arrives with the store full is dropped.
                    if (!w_full) begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        w_wdata = '{number: w_number_ext[NUMBER_W-1:0], total: w_sum};
                        n_count = r_count + CW'(1);
                    end
                    if (i_in_data.last_record) begin
                        n_n     = w_full ? r_count : r_count + CW'(1);
                        n_count = '0;
                        n_i     = '0;
                        n_k     = '0;
                        // A set of one record needs no sorting.
                        n_state = (n_n >= CW'(2)) ? S_FETCH : S_ORD;
                    end
                end
            end
            S_FETCH: begin
                w_re    = 1'b1;
                w_raddr = r_i;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_cur   = w_rdata;
                w_re    = 1'b1;
                w_raddr = r_i + AW'(1);
                n_j     = r_i + AW'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // A strictly greater later total takes position i; the record
                // held so far moves to position j, exactly as a swap would.
                if (w_rdata.total > r_cur.total) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_cur;
                    n_cur   = w_rdata;
                end
                if (CW'(r_j) == r_n - CW'(1)) begin
                    n_state = S_PUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_j + AW'(1);
                    n_j     = r_j + AW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_cur;
                if ((CW + 1)'(r_i) + (CW + 1)'(2) >= (CW + 1)'(r_n)) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_FETCH;
                end
            end
            S_ORD: begin
                w_re    = 1'b1;
                w_raddr = r_k;
                n_state = S_OCAP;
            end
            S_OCAP: begin
                n_out   = '{record_number: w_rdata.number,
                            total_score:   w_rdata.total,
                            last_out:      (CW'(r_k) + CW'(1) == r_n)};
                n_state = S_OHOLD;
            end
            S_OHOLD: begin
                if (!i_out_stall) begin
                    if (r_out.last_out) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next sorted record as this one leaves.
                        w_re    = 1'b1;
                        w_raddr = r_k + AW'(1);
                        n_k     = r_k + AW'(1);
                        n_state = S_OCAP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_cur <= n_cur;
        r_out <= n_out;
    end

    rsbt_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OHOLD);
    assign o_out_data  = r_out;

    // The scan index always lies beyond the pass position.
    a_scan_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j > r_i))
        else $error("scan index not beyond pass position");

    // No request is taken while a result is on offer.
    a_no_load_in_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    // The record count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECORDS))
        else $error("record count beyond store depth");

    // After the final result of a run leaves, the block takes requests again.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_out) |=> !o_in_stall)
        else $error("block not idle after final result");

    // A result that is stalled stays on offer.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result withdrawn");

endmodule

FILE: dv/tb_record_sort_by_total_desc_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the descending record sort.
// A ranking board predicts every set: it stores the total and serial number of each
// request and ranks the set with the same exchange sort when the last request arrives.
// Each result that the block hands over is checked against the oldest pending rank.

module tb_record_sort_by_total_desc_unit
    import rsbt_pkg::*;
();

    localparam int MAX_RECORDS      = 64;
    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 11;
    localparam int MAX_GAP          = 8;
    localparam int RANDOM_ITEMS     = 150;
    localparam int FULL_SET_AT      = 40;
    localparam int OVERFLOW_SET_AT  = 90;
    localparam int LONG_HOLD_AT     = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int TIMEOUT_CYCLES   = 250_000;
    localparam int REPORT_LIMIT     = 10;

    // Predicts the ranked output of each set and checks the block's results in order.
    class ranking_board;
        logic [TOTAL_W-1:0]  totals[MAX_RECORDS];
        logic [NUMBER_W-1:0] numbers[MAX_RECORDS];
        int unsigned         stored;
        t_out_item           ranked_q[$];
        int unsigned         failures;
        int unsigned         results_seen;

        function new();
            stored       = 0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return ranked_q.size();
        endfunction

        // Store an accepted request and, on the last one, rank the whole set.
        function void note_request(t_in_item req);
            logic [TOTAL_W-1:0]  a;
            logic [TOTAL_W-1:0]  b;
            logic [TOTAL_W-1:0]  c;
            logic [TOTAL_W-1:0]  t_swap;
            logic [NUMBER_W-1:0] n_swap;
            t_out_item           rank;
            int unsigned         i;
            int unsigned         j;
            a = TOTAL_W'(req.score_first);
            b = TOTAL_W'(req.score_second);
            c = TOTAL_W'(req.score_third);
            // A request that finds the store full is dropped, but its last flag still counts.
            if (stored < MAX_RECORDS) begin
                totals[stored]  = a + b + c;
                numbers[stored] = NUMBER_W'(stored + 1);
                stored++;
            end
            if (!req.last_record) begin
                return;
            end
            // Exchange sort: position i swaps with a later j only when total j is greater.
            for (i = 0; i + 1 < stored; i++) begin
                for (j = i + 1; j < stored; j++) begin
                    if (totals[j] > totals[i]) begin
                        t_swap     = totals[j];
                        totals[j]  = totals[i];
                        totals[i]  = t_swap;
                        n_swap     = numbers[j];
                        numbers[j] = numbers[i];
                        numbers[i] = n_swap;
                    end
                end
            end
            for (i = 0; i < stored; i++) begin
                rank.record_number = numbers[i];
                rank.total_score   = totals[i];
                rank.last_out      = (i + 1 == stored);
                ranked_q.push_back(rank);
            end
            stored = 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (ranked_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("ERROR: unexpected result: number %0d total %0d last %0b",
                             got.record_number, got.total_score, got.last_out);
                end
                return;
            end
            want = ranked_q.pop_front();
            if (got.record_number !== want.record_number ||
                got.total_score !== want.total_score ||
                got.last_out !== want.last_out) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display({"ERROR: result %0d: expected number %0d total %0d last %0b, ",
                              "got number %0d total %0d last %0b"},
                             results_seen, want.record_number, want.total_score,
                             want.last_out, got.record_number, got.total_score,
                             got.last_out);
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    ranking_board board = new();

    // Set per set of requests: when high the sender offers back to back.
    bit          in_burst;
    int unsigned requests_sent;

    record_sort_by_total_desc_unit #(
        .MAX_RECORDS(MAX_RECORDS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Reset is synchronous, so it is held for a number of edges and then released once.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs: the slowest correct run is far shorter.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ERROR: timeout with %0d results still pending", board.pending());
        $display("** record_sort_by_total_desc_unit: FAILED **");
        $finish;
    end

    // Offers one request after a random gap and returns at the edge that accepts it.
    // Valid is raised without looking at stall, and the payload holds while stalled.
    task automatic send_request(input t_in_item req);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid === 1'b1 && o_in_stall === 1'b0));
        board.note_request(req);
        requests_sent++;
    endtask

    task automatic send_scores(input int unsigned first, input int unsigned second,
                               input int unsigned third, input bit last);
        t_in_item req;
        req.score_first  = SCORE_W'(first);
        req.score_second = SCORE_W'(second);
        req.score_third  = SCORE_W'(third);
        req.last_record  = last;
        send_request(req);
    endtask

    // Mostly legal scores, with the extremes, values above 1000 that the field still
    // allows, and a narrow palette that makes equal totals and so tests tie order.
    function automatic logic [SCORE_W-1:0] draw_score(input bit narrow);
        if (narrow) begin
            case ($urandom_range(0, 2))
                0: return SCORE_W'(0);
                1: return SCORE_W'(500);
                default: return SCORE_W'(1000);
            endcase
        end
        case ($urandom_range(0, 9))
            0: return SCORE_W'(0);
            1: return SCORE_W'(1000);
            2: return SCORE_W'(1023);
            3: return SCORE_W'($urandom_range(1001, 1023));
            4: return SCORE_W'($urandom_range(0, 1023));
            default: return SCORE_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Sends one set of n requests; the last one is flagged and starts the sort.
    task automatic send_set(input int unsigned n);
        t_in_item    req;
        bit          narrow;
        int unsigned k;
        in_burst = ($urandom_range(0, 3) == 0);
        narrow   = ($urandom_range(0, 3) == 0);
        for (k = 1; k <= n; k++) begin
            req.score_first  = draw_score(narrow);
            req.score_second = draw_score(narrow);
            req.score_third  = draw_score(narrow);
            req.last_record  = (k == n);
            send_request(req);
        end
    endtask

    initial begin : request_side
        int unsigned random_start;
        bit          full_done;
        bit          overflow_done;
        full_done     = 1'b0;
        overflow_done = 1'b0;
        requests_sent = 0;
        in_burst      = 1'b0;
        do begin
            @(posedge i_clk);
        end while (i_rst_n !== 1'b1);

        // A set of one record.
        send_scores(0, 0, 0, 1'b1);
        // Largest legal and largest possible totals, then three records tied at 1023.
        send_scores(1000, 1000, 1000, 1'b0);
        send_scores(1023, 1023, 1023, 1'b0);
        send_scores(0, 0, 0, 1'b0);
        send_scores(1023, 0, 0, 1'b0);
        send_scores(0, 1023, 0, 1'b0);
        send_scores(0, 0, 1023, 1'b1);
        // Alternating bit patterns, then three records tied at 1000.
        send_scores(682, 341, 682, 1'b0);
        send_scores(341, 682, 341, 1'b0);
        send_scores(500, 250, 250, 1'b0);
        send_scores(250, 500, 250, 1'b0);
        send_scores(1, 2, 997, 1'b1);
        // Ascending totals, so the sort has to reverse the whole set.
        send_scores(1, 0, 0, 1'b0);
        send_scores(2, 0, 0, 1'b0);
        send_scores(3, 0, 0, 1'b0);
        send_scores(4, 0, 0, 1'b1);
        // Two identical records must keep their load order.
        send_scores(7, 7, 7, 1'b0);
        send_scores(7, 7, 7, 1'b1);

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            if (!full_done && requests_sent - random_start >= FULL_SET_AT) begin
                // A set that fills the store exactly. Afterwards the sender stays quiet
                // until every result of it has been handed over.
                send_set(MAX_RECORDS);
                full_done = 1'b1;
                i_in_valid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end else if (!overflow_done && requests_sent - random_start >= OVERFLOW_SET_AT) begin
                // Two requests beyond a full store: both are dropped, the last still sorts.
                send_set(MAX_RECORDS + 2);
                overflow_done = 1'b1;
            end else begin
                send_set($urandom_range(1, 10));
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("** record_sort_by_total_desc_unit: PASSED **");
        end else begin
            $display("ERROR: %0d failed checks", board.failures);
            $display("** record_sort_by_total_desc_unit: FAILED **");
        end
        $finish;
    end

    // The result side draws a stall before each result. Now and then it runs without
    // stalls, and once it holds off for a long stretch while requests keep coming,
    // so the block backs up into its request side.
    initial begin : result_side
        int unsigned hold;
        bit          quiet;
        bit          long_hold_done;
        quiet          = 1'b0;
        long_hold_done = 1'b0;
        do begin
            @(posedge i_clk);
        end while (i_rst_n !== 1'b1);
        forever begin
            if (!long_hold_done && board.results_seen >= LONG_HOLD_AT) begin
                hold           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            board.check_result(o_out_data);
            if (board.results_seen % 24 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
        end
    end

endmodule

FILE: record_sort_by_total_desc_unit.f
hw/rtl/rsbt_pkg.sv
hw/rtl/rsbt_ram.sv
hw/rtl/record_sort_by_total_desc_unit.sv
dv/tb_record_sort_by_total_desc_unit.sv
